// ----- rtl/core/system_timebase_top_defines.svh -----
// Assertion macros shared by the system timebase checker.
`ifndef SYSTEM_TIMEBASE_TOP_DEFINES_SVH
`define SYSTEM_TIMEBASE_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define STB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("system timebase check failed");

// Next-cycle implication, off while reset is high.
`define STB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("system timebase check failed");

// Next-cycle implication that also holds through reset.
`define STB_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("system timebase check failed");

`endif

// ----- rtl/core/stb_pkg.sv -----
// Constants and request codes for the system timebase.
package stb_pkg;

   // Ticks are shifted left by this much before they are added
   localparam int TICK_SHIFT = 0;
   // Bit position of the one-second unit in a 64-bit time
   localparam int LSHIFT     = 10 + TICK_SHIFT;

   localparam int REQ_W  = 3;
   localparam int WORD_W = 32;
   localparam int TIME_W = 64;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_INIT_FULL = 3'd0;
   localparam logic [REQ_W-1:0] REQ_INIT_UTC  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_SET_FULL  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_SET_UTC   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_ADD_CLK   = 3'd4;
   localparam logic [REQ_W-1:0] REQ_ADD_TICK  = 3'd5;
   localparam logic [REQ_W-1:0] REQ_QUERY     = 3'd6;

   localparam int REQ_DATA_W = 6 * WORD_W;
   localparam int RSP_DATA_W = 7 * WORD_W;

endpackage

// ----- rtl/core/system_timebase_top.sv -----
// System timebase: 64-bit system and start times with init, set, add and query requests.
//
// Usage:
//   Requests enter on the req_ stream: req_tuser carries the request kind,
//   req_tdata the time words, UTC seconds, subseconds, add amount and the
//   current hardware timer count. Every request gives exactly one item on
//   the rsp_ stream with the stored time, live time, UTC seconds and uptime.
//   One second is bit 10 + TICK_SHIFT of the 64-bit time.
// Pipeline and throughput:
//   A request is captured in an input register and its result then lands
//   in the output register, which drives rsp_tvalid and rsp_tdata. One
//   request per cycle is sustained while rsp_tready stays high; the update
//   of the two 64-bit time registers in one combinational step sets that figure.
// Reset:
//   Synchronous reset clears both times to zero and empties both registers.
// Stalls:
//   While rsp_tready is low the result holds; one more request may wait in
//   the input register, after which req_tready drops until the result leaves.
module system_timebase_top (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [stb_pkg::REQ_W-1:0]     req_tuser,  // req_type
   // time_upper, time_clocks, utc, subseconds, amount, live_count (low to high)
   input  logic [stb_pkg::REQ_DATA_W-1:0] req_tdata,
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // base_upper, base_clocks, now_upper, now_clocks, utc_now, uptime_secs,
   // uptime_clocks (low to high)
   output logic [stb_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int W = stb_pkg::WORD_W;
   localparam int L = stb_pkg::LSHIFT;

   // Input register
   logic                           in_valid_ff;
   logic [stb_pkg::REQ_W-1:0]      in_type_ff;
   logic [stb_pkg::REQ_DATA_W-1:0] in_data_ff;

   // Result register
   logic                           rsp_valid_ff;
   logic [stb_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [stb_pkg::RSP_DATA_W-1:0] rsp_data_in;

   // Time state
   logic [stb_pkg::TIME_W-1:0] sys_ff;
   logic [stb_pkg::TIME_W-1:0] start_ff;
   logic [stb_pkg::TIME_W-1:0] sys_in;
   logic [stb_pkg::TIME_W-1:0] start_in;

   logic advance;
   logic fire;

   // Unpacked request fields
   logic [W-1:0] time_upper;
   logic [W-1:0] time_clocks;
   logic [W-1:0] utc;
   logic [W-1:0] subseconds;
   logic [W-1:0] amount;
   logic [W-1:0] live_count;

   logic [stb_pkg::TIME_W-1:0] full_time;
   logic [stb_pkg::TIME_W-1:0] utc_stamp;
   logic [stb_pkg::TIME_W-1:0] live_wide;
   logic [stb_pkg::TIME_W-1:0] set_target;
   logic [stb_pkg::TIME_W-1:0] now_time;
   logic [W-1:0]               ticks;
   logic [W-1:0]               utc_now;
   logic [W-1:0]               start_secs;

   // Move the held item on when the result register is free or draining
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign time_upper  = in_data_ff[0*W +: W];
   assign time_clocks = in_data_ff[1*W +: W];
   assign utc         = in_data_ff[2*W +: W];
   assign subseconds  = in_data_ff[3*W +: W];
   assign amount      = in_data_ff[4*W +: W];
   assign live_count  = in_data_ff[5*W +: W];

   // Build candidate time values
   assign full_time  = {time_upper, time_clocks};
   assign utc_stamp  = {{W{1'b0}}, utc} << L;
   assign live_wide  = {{W{1'b0}}, live_count};
   assign ticks      = amount << stb_pkg::TICK_SHIFT;
   assign set_target = (in_type_ff == stb_pkg::REQ_SET_FULL) ? full_time
                     : (utc_stamp | {{W{1'b0}}, subseconds});

   // Next state for the request kind
   always_comb begin
      sys_in   = sys_ff;
      start_in = start_ff;
      case (in_type_ff)
         stb_pkg::REQ_INIT_FULL: begin
            sys_in   = full_time;
            start_in = full_time;
         end
         stb_pkg::REQ_INIT_UTC: begin
            sys_in   = utc_stamp;
            start_in = utc_stamp;
         end
         stb_pkg::REQ_SET_FULL, stb_pkg::REQ_SET_UTC: begin
            // shift start by (target - sys - live) so uptime carries over
            sys_in   = set_target;
            start_in = start_ff + set_target - sys_ff - live_wide;
         end
         stb_pkg::REQ_ADD_CLK: begin
            sys_in = sys_ff + {{W{1'b0}}, amount};
         end
         stb_pkg::REQ_ADD_TICK: begin
            sys_in = sys_ff + {{W{1'b0}}, ticks};
         end
         default: begin
            // query and the unused code leave the state alone
            sys_in   = sys_ff;
            start_in = start_ff;
         end
      endcase
   end

   // Derive the result from the updated state
   assign now_time   = sys_in + live_wide;
   assign utc_now    = now_time[L +: W];
   assign start_secs = start_in[L +: W];
   assign rsp_data_in = {now_time[W-1:0] - start_in[W-1:0],
                         utc_now - start_secs,
                         utc_now,
                         now_time[W-1:0],
                         now_time[2*W-1:W],
                         sys_in[W-1:0],
                         sys_in[2*W-1:W]};

   // Control and time state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sys_ff       <= '0;
         start_ff     <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            sys_ff   <= sys_in;
            start_ff <= start_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_type_ff <= req_tuser;
         in_data_ff <= req_tdata;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- rtl/core/stb_checker.sv -----
// Port-level checks for the system timebase, bound to the top level.
`include "system_timebase_top_defines.svh"

module stb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [stb_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int W = stb_pkg::WORD_W;

   logic [stb_pkg::TIME_W-1:0] base_time;
   logic [stb_pkg::TIME_W-1:0] now_time;
   logic [stb_pkg::TIME_W-1:0] live_gap;

   assign base_time = {rsp_tdata[0*W +: W], rsp_tdata[1*W +: W]};
   assign now_time  = {rsp_tdata[2*W +: W], rsp_tdata[3*W +: W]};
   assign live_gap  = now_time - base_time;

   // Reset empties the result side
   `STB_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_tvalid)
   // A stalled result stays and holds its payload
   `STB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // Input only backs up when a result is waiting
   `STB_ASSERT_NOW(a_backpressure, !req_tready, rsp_tvalid && !rsp_tready)
   // Live time is the base plus a 32-bit timer count
   `STB_ASSERT_NOW(a_live_gap, rsp_tvalid, live_gap[stb_pkg::TIME_W-1:W] == '0)
   // UTC seconds are taken from the live time
   `STB_ASSERT_NOW(a_utc_bits, rsp_tvalid, rsp_tdata[4*W +: W] == now_time[stb_pkg::LSHIFT +: W])

endmodule

bind system_timebase_top stb_checker u_stb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- dv/system_timebase_checker.sv -----
// Checker for the system timebase: tracks both times, predicts each result item and compares.
`timescale 1ns / 1ps

module system_timebase_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [stb_pkg::REQ_W-1:0]      req_tuser,  // req_type
   // time_upper, time_clocks, utc, subseconds, amount, live_count (low to high)
   input  logic [stb_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // base_upper, base_clocks, now_upper, now_clocks, utc_now, uptime_secs,
   // uptime_clocks (low to high)
   input  logic [stb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             fail_count,
   output int                             outstanding,
   output int                             results_checked
);
   import stb_pkg::*;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [TIME_W-1:0] stamp_type;

   // Packed structs list the highest field first, so the last field lands in bit 0
   typedef struct packed {
      word_type live_count;
      word_type amount;
      word_type subseconds;
      word_type utc;
      word_type time_clocks;
      word_type time_upper;
   } timebase_req_type;

   typedef struct packed {
      word_type uptime_clocks;
      word_type uptime_secs;
      word_type utc_now;
      word_type now_clocks;
      word_type now_upper;
      word_type base_clocks;
      word_type base_upper;
   } timebase_rsp_type;

   stamp_type        base_time;
   stamp_type        origin_time;
   timebase_rsp_type expected_stamps[$];
   timebase_rsp_type got_rsp;
   timebase_rsp_type want_rsp;

   task automatic report_error(input string msg);
      fail_count++;
      $display("[%0t] timebase mismatch: %s", $realtime, msg);
   endtask

   task automatic check_word(input string field, input word_type got, input word_type want);
      if (got !== want) begin
         report_error($sformatf("%s got %08h expected %08h (result %0d)",
                                field, got, want, results_checked));
      end
   endtask

   // Apply one request to the tracked times and return the result it gives
   function automatic timebase_rsp_type advance_timebase(input timebase_req_type rq,
                                                         input logic [REQ_W-1:0] kind);
      stamp_type        full_val;
      stamp_type        utc_val;
      stamp_type        live_val;
      stamp_type        now_val;
      word_type         ticks;
      word_type         start_secs;
      timebase_rsp_type rs;

      full_val = {rq.time_upper, rq.time_clocks};
      utc_val  = {32'b0, rq.utc} << LSHIFT;
      live_val = base_time + {32'b0, rq.live_count};
      ticks    = rq.amount << TICK_SHIFT;

      case (kind)
         REQ_INIT_FULL: begin
            base_time   = full_val;
            origin_time = full_val;
         end
         REQ_INIT_UTC: begin
            base_time   = utc_val;
            origin_time = utc_val;
         end
         // Move the base to the target and shift the origin by target minus live time so uptime holds
         REQ_SET_FULL: begin
            origin_time = origin_time + (full_val - live_val);
            base_time   = full_val;
         end
         REQ_SET_UTC: begin
            origin_time = origin_time + ((utc_val | {32'b0, rq.subseconds}) - live_val);
            base_time   = utc_val | {32'b0, rq.subseconds};
         end
         REQ_ADD_CLK:  base_time = base_time + {32'b0, rq.amount};
         REQ_ADD_TICK: base_time = base_time + {32'b0, ticks};
         default: ;
      endcase

      now_val          = base_time + {32'b0, rq.live_count};
      start_secs       = origin_time[LSHIFT +: WORD_W];
      rs.base_upper    = base_time[63:32];
      rs.base_clocks   = base_time[31:0];
      rs.now_upper     = now_val[63:32];
      rs.now_clocks    = now_val[31:0];
      rs.utc_now       = now_val[LSHIFT +: WORD_W];
      rs.uptime_secs   = rs.utc_now - start_secs;
      rs.uptime_clocks = now_val[31:0] - origin_time[31:0];
      return rs;
   endfunction

   // Predict on each accepted request, compare on each accepted result
   always @(posedge clock) begin
      if (reset) begin
         base_time   = '0;
         origin_time = '0;
         expected_stamps.delete();
         outstanding = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_stamps.push_back(advance_timebase(timebase_req_type'(req_tdata),
                                                       req_tuser));
         end
         if (rsp_tvalid && rsp_tready) begin
            got_rsp = timebase_rsp_type'(rsp_tdata);
            if (expected_stamps.size() == 0) begin
               report_error("result item with no request outstanding");
            end else begin
               want_rsp = expected_stamps.pop_front();
               check_word("base_upper", got_rsp.base_upper, want_rsp.base_upper);
               check_word("base_clocks", got_rsp.base_clocks, want_rsp.base_clocks);
               check_word("now_upper", got_rsp.now_upper, want_rsp.now_upper);
               check_word("now_clocks", got_rsp.now_clocks, want_rsp.now_clocks);
               check_word("utc_now", got_rsp.utc_now, want_rsp.utc_now);
               check_word("uptime_secs", got_rsp.uptime_secs, want_rsp.uptime_secs);
               check_word("uptime_clocks", got_rsp.uptime_clocks, want_rsp.uptime_clocks);
               results_checked++;
            end
         end
         outstanding = expected_stamps.size();
      end
   end

endmodule

// ----- dv/system_timebase_top_tb.sv -----
// Testbench top for the system timebase: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module system_timebase_top_tb;
   import stb_pkg::*;

   // Code left unused by the block; it must behave as a query
   localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
   localparam int RANDOM_ITEMS = 950;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 120;
   localparam int CYCLE_LIMIT  = 200000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tuser;   // req_type
   // time_upper, time_clocks, utc, subseconds, amount, live_count (low to high)
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // base_upper, base_clocks, now_upper, now_clocks, utc_now, uptime_secs,
   // uptime_clocks (low to high)
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int fail_count;
   int outstanding;
   int results_checked;
   int items_sent;
   int results_taken;
   int cycle_count;
   int kind_seen [8];

   system_timebase_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   system_timebase_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tuser       (req_tuser),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Abort a run that stops making progress
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL system_timebase_top");
         $finish;
      end
   end

   // Mostly random words, with the extremes and near-extremes mixed in
   function automatic logic [WORD_W-1:0] draw_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(0, 1023);
         3:       return 32'hFFFF_FFFF - $urandom_range(0, 1023);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [REQ_W-1:0] draw_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6)       return REQ_INIT_FULL;
      else if (r < 12) return REQ_INIT_UTC;
      else if (r < 30) return REQ_SET_FULL;
      else if (r < 48) return REQ_SET_UTC;
      else if (r < 66) return REQ_ADD_CLK;
      else if (r < 82) return REQ_ADD_TICK;
      else if (r < 95) return REQ_QUERY;
      else             return REQ_UNUSED;
   endfunction

   // Offer one request item, after a random gap outside the back-to-back stretches, and hold it until accepted
   task automatic send_request(input logic [REQ_W-1:0] kind,
                               input logic [WORD_W-1:0] upper, input logic [WORD_W-1:0] clocks,
                               input logic [WORD_W-1:0] utc, input logic [WORD_W-1:0] subs,
                               input logic [WORD_W-1:0] amount, input logic [WORD_W-1:0] live);
      int gap;
      gap = ((items_sent / 50) % 3 == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {live, amount, subs, utc, clocks, upper};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      kind_seen[kind]++;
      @(negedge clock);
   endtask

   // Take result items with random stalls and one long hold-off
   initial begin
      int stall;
      rsp_tready    = 1'b0;
      results_taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = ((results_taken / 64) % 3 == 1) ? 0 : $urandom_range(0, 8);
         if (results_taken == HOLD_AT) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         results_taken++;
         @(negedge clock);
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      items_sent = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes, every request kind and the wrap cases
      send_request(REQ_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, '0);
      send_request(REQ_INIT_FULL, '1, '1, $urandom, $urandom, $urandom, '1);
      send_request(REQ_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, 32'd1);
      send_request(REQ_INIT_FULL, '0, '0, $urandom, $urandom, $urandom, '0);
      send_request(REQ_INIT_UTC, $urandom, $urandom, '1, $urandom, $urandom, '0);
      send_request(REQ_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, '1);
      send_request(REQ_INIT_UTC, $urandom, $urandom, '0, $urandom, $urandom, 32'd77);
      send_request(REQ_SET_FULL, 32'h1234_5678, 32'h9ABC_DEF0, $urandom, $urandom, $urandom,
                   32'h0000_1000);
      // target below the live time: negative delta into the origin
      send_request(REQ_SET_FULL, '0, '0, $urandom, $urandom, $urandom, '1);
      // subseconds overlap the shifted seconds
      send_request(REQ_SET_UTC, $urandom, $urandom, '1, '1, $urandom, 32'd5);
      send_request(REQ_SET_UTC, $urandom, $urandom, 32'd1, 32'h3FF, $urandom, '0);
      // carry from the low word into the upper word
      send_request(REQ_INIT_FULL, 32'd1, '1, $urandom, $urandom, $urandom, '0);
      send_request(REQ_ADD_CLK, $urandom, $urandom, $urandom, $urandom, 32'd1, '0);
      send_request(REQ_ADD_CLK, $urandom, $urandom, $urandom, $urandom, '1, 32'd3);
      // full 64-bit wrap of the base
      send_request(REQ_INIT_FULL, '1, '1, $urandom, $urandom, $urandom, '0);
      send_request(REQ_ADD_CLK, $urandom, $urandom, $urandom, $urandom, 32'd1, '0);
      // all-ones tick amount, added unshifted since TICK_SHIFT is zero
      send_request(REQ_ADD_TICK, $urandom, $urandom, $urandom, $urandom, '1, '0);
      send_request(REQ_ADD_TICK, $urandom, $urandom, $urandom, $urandom, '0, '1);
      send_request(REQ_UNUSED, '1, '1, '1, '1, '1, 32'h8000_0000);
      send_request(REQ_SET_FULL, '1, '1, $urandom, $urandom, $urandom, '1);
      send_request(REQ_QUERY, '1, '1, '1, '1, '1, '0);

      // Random traffic over all kinds and value classes
      repeat (RANDOM_ITEMS) begin
         send_request(draw_kind(), draw_word(), draw_word(), draw_word(), draw_word(),
                      draw_word(), draw_word());
      end
      req_tvalid <= 1'b0;

      // Drain, then allow the pipeline latency to settle
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Sent %0d requests: init %0d/%0d, set %0d/%0d, add %0d/%0d, query %0d, code 7 %0d",
               items_sent, kind_seen[REQ_INIT_FULL], kind_seen[REQ_INIT_UTC],
               kind_seen[REQ_SET_FULL], kind_seen[REQ_SET_UTC], kind_seen[REQ_ADD_CLK],
               kind_seen[REQ_ADD_TICK], kind_seen[REQ_QUERY], kind_seen[REQ_UNUSED]);
      $display("Compared %0d results, with a %0d-cycle result stall, %0d mismatches",
               results_checked, HOLD_CYCLES, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS system_timebase_top");
      end else begin
         $display("FAIL system_timebase_top");
      end
      $finish;
   end

endmodule

// ----- system_timebase_top.f -----
+incdir+rtl/core
rtl/core/stb_pkg.sv
rtl/core/system_timebase_top.sv
rtl/core/stb_checker.sv
dv/system_timebase_checker.sv
dv/system_timebase_top_tb.sv
